>>> hdl/arplm_pkg.sv
// Shared types and constants of the audio RMS and peak level meter.
package arplm_pkg;

   // Sample width is fixed by the item format
   localparam int SAMPLE_BITS = 16;
   // Power word: squared magnitude shifted up to a full-scale of 2^54
   localparam int POWER_BITS  = 56;
   localparam int POW_EXTRA   = 54 - 2 * (SAMPLE_BITS - 1);
   // Power is split into a low and a high chunk for the coefficient multiply
   localparam int LO_BITS     = 32;
   localparam int HI_BITS     = POWER_BITS - LO_BITS;
   // Square root: two result bits per cycle
   localparam int ROOT_BITS   = POWER_BITS / 2;
   localparam int REM_BITS    = ROOT_BITS + 2;
   localparam int SQRT_STEPS  = 2;
   localparam int ROOT_CYCLES = ROOT_BITS / SQRT_STEPS;
   localparam int CNT_BITS    = $clog2(ROOT_CYCLES);

   // Coefficient reset values, Q0.24
   localparam logic [31:0] AVG_COEF_RESET   = 32'd1268;
   localparam logic [31:0] PEAK_DECAY_RESET = 32'd16775948;

   // Register indexes
   localparam logic CSR_AVG_COEF   = 1'b0;
   localparam logic CSR_PEAK_DECAY = 1'b1;

   // Item kinds
   localparam logic REQ_SAMPLE = 1'b0;
   localparam logic REQ_FETCH  = 1'b1;

   typedef struct packed {
      logic                          req_type;
      logic signed [SAMPLE_BITS-1:0] sample;
   } arplm_req_type;

   typedef struct packed {
      logic [SAMPLE_BITS-1:0] rms_level;
      logic [SAMPLE_BITS-1:0] peak_level;
      logic [SAMPLE_BITS-1:0] hold_level;
      logic [SAMPLE_BITS-1:0] clip_level;
   } arplm_rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SQUARE,
      ST_COMPARE,
      ST_MUL_LO,
      ST_MUL_HI,
      ST_SCALE,
      ST_WRITE,
      ST_ROOT,
      ST_DELIVER
   } arplm_state_type;

   typedef struct packed {
      logic take_sample;
      logic take_fetch;
      logic square;
      logic compare;
      logic load_peak;
      logic mul_lo;
      logic mul_hi;
      logic sel_decay;
      logic scale;
      logic write_mean;
      logic write_peak;
      logic root_step;
      logic out_load;
   } arplm_cmd_type;

   typedef struct packed {
      logic peak_rise;
   } arplm_status_type;

endpackage

>>> hdl/arplm_sqrt.sv
// Digit-by-digit floor square root, two result bits per cycle while step is high.
module arplm_sqrt
   import arplm_pkg::*;
(
   input  logic                  clock,
   input  logic                  load,
   input  logic                  step,
   input  logic [POWER_BITS-1:0] radicand,
   output logic [ROOT_BITS-1:0]  root
);

   logic [POWER_BITS-1:0] x_ff, x_in;
   logic [REM_BITS-1:0]   rem_ff, rem_in;
   logic [ROOT_BITS-1:0]  root_ff, root_in;
   logic [REM_BITS-1:0]   shifted;
   logic [REM_BITS-1:0]   trial;

   always_comb begin
      x_in    = x_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      shifted = '0;
      trial   = '0;
      for (int i = 0; i < SQRT_STEPS; i++) begin
         // bring down the next two radicand bits
         shifted = {rem_in[REM_BITS-3:0], x_in[POWER_BITS-1 -: 2]};
         x_in    = x_in << 2;
         trial   = {root_in, 2'b01};
         if (shifted >= trial) begin
            rem_in  = shifted - trial;
            root_in = {root_in[ROOT_BITS-2:0], 1'b1};
         end else begin
            rem_in  = shifted;
            root_in = {root_in[ROOT_BITS-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         x_ff    <= radicand;
         rem_ff  <= '0;
         root_ff <= '0;
      end else if (step) begin
         x_ff    <= x_in;
         rem_ff  <= rem_in;
         root_ff <= root_in;
      end
   end

   assign root = root_ff;

endmodule

>>> hdl/arplm_dpath.sv
// Datapath of the level meter: level state, coefficient multiply, roots, result register.
module arplm_dpath
   import arplm_pkg::*;
#(
   parameter int COEF_BITS = 24
) (
   input  logic                 clock,
   input  logic                 reset,
   input  arplm_cmd_type        cmd,
   input  arplm_req_type        req_data,
   input  logic                 csr_we,
   input  logic                 csr_addr,
   input  logic [COEF_BITS-1:0] csr_wdata,
   output arplm_status_type     status,
   output arplm_rsp_type        rsp_data
);

   localparam int MUL_BITS  = LO_BITS + COEF_BITS;
   localparam int PHI_BITS  = HI_BITS + COEF_BITS;
   localparam int ACC_BITS  = POWER_BITS + COEF_BITS;

   logic [COEF_BITS-1:0]     avg_coef_ff, peak_decay_ff;
   logic [POWER_BITS-1:0]    mean_ff, peak_ff, power_ff, p_ff, scaled_ff;
   logic [SAMPLE_BITS-1:0]   hold_ff, clip_ff, mag_ff, hold_snap_ff, clip_snap_ff;
   logic                     mean_up_ff, peak_rise_ff;
   logic [LO_BITS-1:0]       mul_a;
   logic [COEF_BITS-1:0]     coef_sel;
   logic [MUL_BITS-1:0]      product;
   logic [MUL_BITS-1:0]      prod_lo_ff;
   logic [PHI_BITS-1:0]      prod_hi_ff;
   logic [ACC_BITS-1:0]      acc;
   logic [SAMPLE_BITS-1:0]   raw;
   logic [SAMPLE_BITS-1:0]   mag;
   logic [2*SAMPLE_BITS-1:0] square;
   logic                     mean_up;
   logic [POWER_BITS-1:0]    diff;
   logic [ROOT_BITS-1:0]     root_mean, root_peak;
   arplm_rsp_type            rsp_ff;

   // magnitude; the most negative sample maps to 2^(SAMPLE_BITS-1)
   assign raw    = req_data.sample;
   assign mag    = raw[SAMPLE_BITS-1] ? (SAMPLE_BITS'(0) - raw) : raw;
   assign square = {{SAMPLE_BITS{1'b0}}, mag_ff} * {{SAMPLE_BITS{1'b0}}, mag_ff};

   assign mean_up = power_ff >= mean_ff;
   assign diff    = mean_up ? (power_ff - mean_ff) : (mean_ff - power_ff);

   // one 32 x coefficient multiplier, shared by both chunks and both passes
   assign mul_a    = cmd.mul_hi ? LO_BITS'(p_ff[POWER_BITS-1:LO_BITS]) : p_ff[LO_BITS-1:0];
   assign coef_sel = cmd.sel_decay ? peak_decay_ff : avg_coef_ff;
   assign product  = MUL_BITS'(mul_a) * MUL_BITS'(coef_sel);
   assign acc      = {prod_hi_ff, {LO_BITS{1'b0}}} + ACC_BITS'(prod_lo_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         avg_coef_ff   <= COEF_BITS'(AVG_COEF_RESET);
         peak_decay_ff <= COEF_BITS'(PEAK_DECAY_RESET);
      end else if (csr_we) begin
         unique case (csr_addr)
            CSR_AVG_COEF:   avg_coef_ff   <= csr_wdata;
            CSR_PEAK_DECAY: peak_decay_ff <= csr_wdata;
            default:        ;
         endcase
      end
   end

   // level state
   always_ff @(posedge clock) begin
      if (reset) begin
         mean_ff <= '0;
         peak_ff <= '0;
         hold_ff <= '0;
         clip_ff <= '0;
      end else begin
         if (cmd.square) begin
            if (clip_ff < mag_ff) clip_ff <= mag_ff;
            if (hold_ff < mag_ff) hold_ff <= mag_ff;
         end else if (cmd.take_fetch) begin
            hold_ff <= '0;
         end
         if (cmd.write_mean) begin
            mean_ff <= mean_up_ff ? (mean_ff + scaled_ff) : (mean_ff - scaled_ff);
         end
         if (cmd.write_peak) begin
            peak_ff <= peak_rise_ff ? power_ff : scaled_ff;
         end
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      if (cmd.take_sample) mag_ff <= mag;
      if (cmd.square) power_ff <= POWER_BITS'(square) << POW_EXTRA;
      if (cmd.compare) begin
         mean_up_ff   <= mean_up;
         peak_rise_ff <= peak_ff < power_ff;
         p_ff         <= diff;
      end else if (cmd.load_peak) begin
         p_ff <= peak_ff;
      end
      if (cmd.mul_lo) prod_lo_ff <= product;
      if (cmd.mul_hi) prod_hi_ff <= product[PHI_BITS-1:0];
      if (cmd.scale) scaled_ff <= acc[COEF_BITS +: POWER_BITS];
      if (cmd.take_fetch) begin
         hold_snap_ff <= hold_ff;
         clip_snap_ff <= clip_ff;
      end
      if (cmd.out_load) begin
         rsp_ff.rms_level  <= root_mean[ROOT_BITS-1 -: SAMPLE_BITS];
         rsp_ff.peak_level <= root_peak[ROOT_BITS-1 -: SAMPLE_BITS];
         rsp_ff.hold_level <= hold_snap_ff;
         rsp_ff.clip_level <= clip_snap_ff;
      end
   end

   arplm_sqrt u_sqrt_mean (
      .clock    (clock),
      .load     (cmd.take_fetch),
      .step     (cmd.root_step),
      .radicand (mean_ff),
      .root     (root_mean)
   );

   arplm_sqrt u_sqrt_peak (
      .clock    (clock),
      .load     (cmd.take_fetch),
      .step     (cmd.root_step),
      .radicand (peak_ff),
      .root     (root_peak)
   );

   assign status.peak_rise = peak_rise_ff;
   assign rsp_data         = rsp_ff;

endmodule

>>> hdl/arplm_ctrl.sv
// Controller of the level meter: sequences sample updates, fetches and result handoff.
module arplm_ctrl
   import arplm_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_kind,
   output logic             req_stall,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   input  arplm_status_type status,
   output arplm_cmd_type    cmd
);

   arplm_state_type     state_ff, state_in;
   logic                pass_ff, pass_in;
   logic [CNT_BITS-1:0] cnt_ff, cnt_in;
   logic                rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pass_ff      <= 1'b0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pass_ff      <= pass_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in      = state_ff;
      pass_in       = pass_ff;
      cnt_in        = cnt_ff;
      cmd           = '0;
      cmd.sel_decay = pass_ff;
      req_stall     = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               if (req_kind == REQ_FETCH) begin
                  cmd.take_fetch = 1'b1;
                  cnt_in         = '0;
                  state_in       = ST_ROOT;
               end else begin
                  cmd.take_sample = 1'b1;
                  state_in        = ST_SQUARE;
               end
            end
         end
         ST_SQUARE: begin
            cmd.square = 1'b1;
            state_in   = ST_COMPARE;
         end
         ST_COMPARE: begin
            cmd.compare = 1'b1;
            pass_in     = 1'b0;
            state_in    = ST_MUL_LO;
         end
         ST_MUL_LO: begin
            cmd.mul_lo = 1'b1;
            state_in   = ST_MUL_HI;
         end
         ST_MUL_HI: begin
            cmd.mul_hi = 1'b1;
            state_in   = ST_SCALE;
         end
         ST_SCALE: begin
            cmd.scale = 1'b1;
            state_in  = ST_WRITE;
         end
         ST_WRITE: begin
            if (!pass_ff) begin
               cmd.write_mean = 1'b1;
               if (status.peak_rise) begin
                  // new peak: take the power directly, no decay pass
                  cmd.write_peak = 1'b1;
                  state_in       = ST_IDLE;
               end else begin
                  cmd.load_peak = 1'b1;
                  pass_in       = 1'b1;
                  state_in      = ST_MUL_LO;
               end
            end else begin
               cmd.write_peak = 1'b1;
               state_in       = ST_IDLE;
            end
         end
         ST_ROOT: begin
            cmd.root_step = 1'b1;
            cnt_in        = cnt_ff + 1'b1;
            if (cnt_ff == CNT_BITS'(ROOT_CYCLES - 1)) state_in = ST_DELIVER;
         end
         ST_DELIVER: begin
            // hold until the result register is free or drains this cycle
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.out_load) rsp_valid_in = 1'b1;
      else if (rsp_valid_ff && !rsp_stall) rsp_valid_in = 1'b0;
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

>>> hdl/audio_rms_peak_level_meter_unit.sv
// Level meter for signed Q1.15 audio: smoothed RMS, decaying peak, hold and clip levels.
// A sample item (req_type 0) updates the clip and hold maxima, moves the mean power toward
// the new squared magnitude by avg_coef and lifts or decays the peak power; it returns
// nothing. A fetch item (req_type 1) returns floor square roots of mean and peak power plus
// hold and clip, then clears hold. One item is in work at a time. A sample is squared and
// compared, then the 56-bit power times a coefficient is formed as 32-bit low and 24-bit
// high chunks on one multiplier, summed and applied; a second pass decays a peak that
// does not rise. A fetch steps two root units at two bits per cycle; the result waits
// in an output register while later sample items proceed. Coefficients are Q0.COEF_BITS.
module audio_rms_peak_level_meter_unit
   import arplm_pkg::*;
#(
   parameter int COEF_BITS = 24
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  arplm_req_type        req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output arplm_rsp_type        rsp_data,
   input  logic                 csr_we,
   input  logic                 csr_addr,
   input  logic [COEF_BITS-1:0] csr_wdata
);

   arplm_cmd_type    cmd;
   arplm_status_type status;

   arplm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_kind  (req_data.req_type),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   arplm_dpath #(
      .COEF_BITS (COEF_BITS)
   ) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .req_data  (req_data),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .status    (status),
      .rsp_data  (rsp_data)
   );

`ifndef SYNTHESIS
   // never overwrite a result that is still waiting
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> !(rsp_valid && rsp_stall))
      else $error("result register overwritten while stalled");

   // every accepted item starts exactly one sequence
   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |-> (cmd.take_sample || cmd.take_fetch))
      else $error("accepted item did not start work");

   // datapath steps are issued one at a time
   a_one_step: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.take_sample, cmd.take_fetch, cmd.square, cmd.compare, cmd.mul_lo,
                cmd.mul_hi, cmd.scale, cmd.root_step, cmd.out_load}))
      else $error("overlapping datapath commands");

   // a fetch cannot deliver before its roots are computed
   a_root_first: assert property (@(posedge clock) disable iff (reset)
      cmd.take_fetch |=> !cmd.out_load)
      else $error("result loaded before root steps");
`endif

endmodule

>>> test/audio_rms_peak_level_meter_unit_tb.sv
// Self-checking testbench for the audio RMS and peak level meter.
module audio_rms_peak_level_meter_unit_tb;
   import arplm_pkg::*;

   localparam int CYCLE_LIMIT     = 400000;
   localparam int PHASES          = 8;
   localparam int ITEMS_PER_PHASE = 94;
   localparam int PRESSURE_PHASE  = 4;
   localparam int SETTLE_CYCLES   = 24;
   localparam int PROBE_ROWS      = 23;
   localparam arplm_rsp_type NO_LEVELS = '0;

   typedef struct packed {
      logic                   kind;
      logic [SAMPLE_BITS-1:0] sample;
      logic                   typed;
      arplm_rsp_type          want;
   } probe_row_type;

   logic          clock     = 1'b0;
   logic          reset     = 1'b1;
   logic          req_valid = 1'b0;
   logic          req_stall;
   arplm_req_type req_data  = '0;
   logic          rsp_valid;
   logic          rsp_stall = 1'b0;
   arplm_rsp_type rsp_data;
   logic          csr_we    = 1'b0;
   logic          csr_addr  = CSR_AVG_COEF;
   logic [23:0]   csr_wdata = '0;

   // Meter state as it should stand after every accepted item
   logic [55:0] mean_pw;
   logic [55:0] peak_pw;
   logic [16:0] hold_mag;
   logic [16:0] clip_mag;
   logic [23:0] avg_coef_q;
   logic [23:0] decay_coef_q;

   arplm_rsp_type pending_levels [$];
   arplm_rsp_type due;
   int            level_errors = 0;
   int            cycles       = 0;
   int            idle_pct     = 0;
   int            stall_pct    = 0;

   probe_row_type probe_rows [PROBE_ROWS] = '{
      '{REQ_FETCH,  16'h7FFF, 1'b1, NO_LEVELS},
      '{REQ_SAMPLE, 16'h0000, 1'b0, NO_LEVELS},
      '{REQ_FETCH,  16'h8000, 1'b1, NO_LEVELS},
      '{REQ_SAMPLE, 16'h8000, 1'b0, NO_LEVELS},
      '{REQ_FETCH,  16'h0000, 1'b0, NO_LEVELS},
      '{REQ_SAMPLE, 16'h7FFF, 1'b0, NO_LEVELS},
      '{REQ_SAMPLE, 16'h7FFF, 1'b0, NO_LEVELS},
      '{REQ_SAMPLE, 16'h7FFF, 1'b0, NO_LEVELS},
      '{REQ_FETCH,  16'hFFFF, 1'b0, NO_LEVELS},
      '{REQ_SAMPLE, 16'h0001, 1'b0, NO_LEVELS},
      '{REQ_SAMPLE, 16'hFFFF, 1'b0, NO_LEVELS},
      '{REQ_FETCH,  16'h1234, 1'b0, NO_LEVELS},
      '{REQ_SAMPLE, 16'h4000, 1'b0, NO_LEVELS},
      '{REQ_SAMPLE, 16'hC000, 1'b0, NO_LEVELS},
      '{REQ_FETCH,  16'h0000, 1'b0, NO_LEVELS},
      '{REQ_SAMPLE, 16'h5555, 1'b0, NO_LEVELS},
      '{REQ_SAMPLE, 16'hAAAA, 1'b0, NO_LEVELS},
      '{REQ_FETCH,  16'h0000, 1'b0, NO_LEVELS},
      '{REQ_FETCH,  16'h0000, 1'b0, NO_LEVELS},
      '{REQ_SAMPLE, 16'h8001, 1'b0, NO_LEVELS},
      '{REQ_SAMPLE, 16'h0064, 1'b0, NO_LEVELS},
      '{REQ_FETCH,  16'h0000, 1'b0, NO_LEVELS},
      '{REQ_FETCH,  16'h0000, 1'b0, NO_LEVELS}
   };

   audio_rms_peak_level_meter_unit i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(0, 99) < stall_pct);
   end

   // floor(p * c / 2^24), exact over the full 80-bit product
   function automatic logic [55:0] coef_scale(input logic [55:0] p, input logic [23:0] c);
      logic [79:0] prod;
      prod = {24'd0, p} * {56'd0, c};
      return prod[79:24];
   endfunction

   // Floored square root of a power word, rescaled to a Q1.15 magnitude
   function automatic logic [15:0] level_root(input logic [55:0] pw);
      logic [27:0] root;
      logic [27:0] trial;
      root = '0;
      for (int b = 27; b >= 0; b--) begin
         trial = root | (28'd1 << b);
         if ({28'd0, trial} * {28'd0, trial} <= pw) root = trial;
      end
      return root[27:12];
   endfunction

   task automatic meter_update(input arplm_req_type item, output bit fetched,
                               output arplm_rsp_type lv);
      logic [16:0] mag;
      logic [55:0] power;
      lv      = NO_LEVELS;
      fetched = 1'b0;
      if (item.req_type == REQ_FETCH) begin
         lv.rms_level  = level_root(mean_pw);
         lv.peak_level = level_root(peak_pw);
         lv.hold_level = hold_mag[15:0];
         lv.clip_level = clip_mag[15:0];
         hold_mag = '0;
         fetched  = 1'b1;
      end else begin
         mag = item.sample[15] ? 17'h10000 - {1'b0, item.sample} : {1'b0, item.sample};
         if (clip_mag < mag) clip_mag = mag;
         if (hold_mag < mag) hold_mag = mag;
         power = ({39'd0, mag} * {39'd0, mag}) << POW_EXTRA;
         // Step toward the new power without passing it
         if (power >= mean_pw) mean_pw = mean_pw + coef_scale(power - mean_pw, avg_coef_q);
         else mean_pw = mean_pw - coef_scale(mean_pw - power, avg_coef_q);
         // A tie counts as no new peak
         if (peak_pw < power) peak_pw = power;
         else peak_pw = coef_scale(peak_pw, decay_coef_q);
      end
   endtask

   task automatic report_mismatch(input string msg);
      $display("level meter error at cycle %0d: %s", cycles, msg);
      level_errors++;
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && rsp_stall == 1'b0) begin
         if (pending_levels.size() == 0) begin
            report_mismatch($sformatf("result %h with no fetch pending", rsp_data));
         end else begin
            due = pending_levels.pop_front();
            if (rsp_data.rms_level !== due.rms_level)
               report_mismatch($sformatf("rms %h, want %h", rsp_data.rms_level, due.rms_level));
            if (rsp_data.peak_level !== due.peak_level)
               report_mismatch($sformatf("peak %h, want %h", rsp_data.peak_level,
                                         due.peak_level));
            if (rsp_data.hold_level !== due.hold_level)
               report_mismatch($sformatf("hold %h, want %h", rsp_data.hold_level,
                                         due.hold_level));
            if (rsp_data.clip_level !== due.clip_level)
               report_mismatch($sformatf("clip %h, want %h", rsp_data.clip_level,
                                         due.clip_level));
         end
      end
   end

   // Enter at a falling edge; return at the falling edge after acceptance
   task automatic send_item(input arplm_req_type item, input logic typed,
                            input arplm_rsp_type want);
      bit            fetched;
      arplm_rsp_type lv;
      while (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (req_stall !== 1'b0) @(posedge clock);
      meter_update(item, fetched, lv);
      if (fetched) pending_levels.push_back(typed ? want : lv);
      @(negedge clock);
   endtask

   // Hold off until every fetch has returned, then let a trailing sample finish
   task automatic drain_levels(input int settle);
      req_valid <= 1'b0;
      @(negedge clock);
      while (pending_levels.size() != 0) @(negedge clock);
      repeat (settle) @(negedge clock);
   endtask

   task automatic write_coef(input logic idx, input logic [23:0] val);
      csr_we    <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_we <= 1'b0;
      if (idx == CSR_AVG_COEF) avg_coef_q = val;
      else decay_coef_q = val;
      @(negedge clock);
   endtask

   task automatic enter_phase(input int ph);
      drain_levels(SETTLE_CYCLES);
      case (ph)
         0: begin
            idle_pct  = 0;
            stall_pct = 0;
         end
         1: begin
            write_coef(CSR_AVG_COEF, 24'hFFFFFF);
            write_coef(CSR_PEAK_DECAY, 24'h000000);
            idle_pct  = 65;
            stall_pct = 0;
         end
         2: begin
            write_coef(CSR_AVG_COEF, 24'h000000);
            write_coef(CSR_PEAK_DECAY, 24'hFFFFFF);
            idle_pct  = 0;
            stall_pct = 65;
         end
         3: begin
            write_coef(CSR_AVG_COEF, 24'h000001);
            write_coef(CSR_PEAK_DECAY, 24'h000001);
            idle_pct  = 35;
            stall_pct = 35;
         end
         4: begin
            write_coef(CSR_AVG_COEF, 24'($urandom_range(1, 65535)));
            write_coef(CSR_PEAK_DECAY, 24'hFFFFFF - 24'($urandom_range(0, 65535)));
            idle_pct  = 0;
            stall_pct = 0;
         end
         5: begin
            write_coef(CSR_AVG_COEF, AVG_COEF_RESET[23:0]);
            write_coef(CSR_PEAK_DECAY, PEAK_DECAY_RESET[23:0]);
            idle_pct  = 65;
            stall_pct = 0;
         end
         6: begin
            write_coef(CSR_AVG_COEF, 24'($urandom_range(24'h800000, 24'hFFFFFF)));
            write_coef(CSR_PEAK_DECAY, 24'($urandom_range(24'hF00000, 24'hFFFFFF)));
            idle_pct  = 0;
            stall_pct = 65;
         end
         default: begin
            write_coef(CSR_AVG_COEF, 24'($urandom));
            write_coef(CSR_PEAK_DECAY, 24'($urandom));
            idle_pct  = 35;
            stall_pct = 35;
         end
      endcase
   endtask

   function automatic logic [15:0] pick_sample(input logic [15:0] prev);
      logic [15:0] mag;
      mag = 16'($urandom_range(0, 255));
      case ($urandom_range(0, 9))
         0: begin
            case ($urandom_range(0, 5))
               0: return 16'h8000;
               1: return 16'h7FFF;
               2: return 16'h0000;
               3: return 16'h0001;
               4: return 16'hFFFF;
               default: return 16'h8001;
            endcase
         end
         // Repeat to land on peak ties
         1: return prev;
         2, 3: return $urandom_range(0, 1) ? -mag : mag;
         default: return 16'($urandom);
      endcase
   endfunction

   initial begin
      arplm_req_type item;
      logic [15:0]   last;
      last         = '0;
      mean_pw      = '0;
      peak_pw      = '0;
      hold_mag     = '0;
      clip_mag     = '0;
      avg_coef_q   = AVG_COEF_RESET[23:0];
      decay_coef_q = PEAK_DECAY_RESET[23:0];
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      for (int r = 0; r < PROBE_ROWS; r++) begin
         item.req_type = probe_rows[r].kind;
         item.sample   = probe_rows[r].sample;
         send_item(item, probe_rows[r].typed, probe_rows[r].want);
      end

      for (int ph = 0; ph < PHASES; ph++) begin
         enter_phase(ph);
         for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
            if (ph == PRESSURE_PHASE && k % 20 == 19) drain_levels(0);
            item.req_type = ($urandom_range(0, 7) == 0) ? REQ_FETCH : REQ_SAMPLE;
            item.sample   = (item.req_type == REQ_FETCH) ? 16'($urandom) : pick_sample(last);
            last          = item.sample;
            send_item(item, 1'b0, NO_LEVELS);
         end
      end

      drain_levels(2 * SETTLE_CYCLES);
      if (level_errors == 0 && pending_levels.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
